>>> rtl/umep_pkg.sv
package umep_pkg;

	localparam logic [3:0] STATUS_SYSTEM   = 4'hF;
	localparam logic [3:0] CIN_SYS_COMMON2 = 4'h2;
	localparam logic [3:0] CIN_SYS_COMMON3 = 4'h3;
	localparam logic [3:0] CIN_SYSEX_START = 4'h4;
	localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
	localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
	localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [23:0] message;
		logic [7:0]  sysex_byte;
		logic        sysex_last;
	} item_t;

	typedef struct packed {
		logic [31:0] packet;
		logic        rejected;
	} result_t;

	typedef struct packed {
		logic        has_result;
		result_t     result;
		logic [15:0] held_bytes;
		logic [1:0]  held_count;
	} enc_t;

	// bit 4 set: unsupported system status
	function automatic logic [4:0] system_code(input logic [3:0] low);
		logic [4:0] code;
		case (low) inside
			4'h0, 4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: code = {1'b0, CIN_SYSEX_START};
			4'h7:       code = {1'b0, CIN_SYSEX_END1};
			4'h1, 4'h3: code = {1'b0, CIN_SYS_COMMON2};
			4'h2:       code = {1'b0, CIN_SYS_COMMON3};
			default:    code = 5'h10;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/umep_if.sv
interface umep_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [23:0] message;
	logic [7:0]  sysex_byte;
	logic        sysex_last;

	modport source (output valid, operation, message, sysex_byte, sysex_last, input ready);
	modport sink   (input valid, operation, message, sysex_byte, sysex_last, output ready);
endinterface

interface umep_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] packet;
	logic        rejected;

	modport source (output valid, packet, rejected, input ready);
	modport sink   (input valid, packet, rejected, output ready);
endinterface

interface umep_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] cable_number;

	modport source (output valid, cable_number, input ready);
	modport sink   (input valid, cable_number, output ready);
endinterface

>>> rtl/umep_encode.sv
module umep_encode (
	input  umep_pkg::item_t  item,
	input  logic [3:0]       cable_number,
	input  logic [15:0]      held_bytes,
	input  logic [1:0]       held_count,
	output umep_pkg::enc_t   enc
);
	import umep_pkg::*;

	logic [4:0]  sys;
	logic [3:0]  code;
	logic [1:0]  count;
	logic [23:0] payload;

	always_comb begin
		sys     = system_code(item.message[3:0]);
		code    = item.message[7:4];
		count   = (held_count > HELD_TWO) ? HELD_TWO : held_count;
		payload = '0;

		enc                 = '0;
		enc.held_bytes      = held_bytes;
		enc.held_count      = held_count;

		if (!item.operation) begin
			enc.has_result = 1'b1;
			if (item.message[7:4] == STATUS_SYSTEM) begin
				code = sys[3:0];
			end
			if ((item.message[7:4] == STATUS_SYSTEM) && sys[4]) begin
				enc.result.rejected = 1'b1;
			end else begin
				enc.result.packet = {item.message, cable_number, code};
			end
		end else if (!item.sysex_last && (count != HELD_TWO)) begin
			if (count == HELD_NONE) begin
				enc.held_bytes[7:0]  = item.sysex_byte;
				enc.held_count       = HELD_ONE;
			end else begin
				enc.held_bytes[15:8] = item.sysex_byte;
				enc.held_count       = HELD_TWO;
			end
		end else begin
			case (count)
				HELD_NONE: begin
					payload = {16'h0000, item.sysex_byte};
					code    = CIN_SYSEX_END1;
				end
				HELD_ONE: begin
					payload = {8'h00, item.sysex_byte, held_bytes[7:0]};
					code    = CIN_SYSEX_END2;
				end
				default: begin
					payload = {item.sysex_byte, held_bytes};
					code    = CIN_SYSEX_END3;
				end
			endcase
			if (!item.sysex_last) begin
				code = CIN_SYSEX_START;
			end
			enc.has_result    = 1'b1;
			enc.result.packet = {payload, cable_number, code};
			enc.held_bytes    = '0;
			enc.held_count    = HELD_NONE;
		end
	end

endmodule

>>> rtl/usb_midi_event_packetizer_core.sv
// USB-MIDI event packetizer.
// Path: a beat taken from the item channel is registered in item_s1, encoded,
// then registered in res_s2, which drives the packet channel; stalls hold both.
// Throughput: one beat per cycle, set by the single encode stage, if not stalled.
// Reset clears the cable number, the held sysex bytes and all valid flags.
module usb_midi_event_packetizer_core (
	input logic         clk,
	input logic         arst_n,
	umep_item_if.sink   items,
	umep_pkt_if.source  packets,
	umep_cfg_if.sink    cfg
);
	import umep_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic [3:0]  cable_q;
	logic [15:0] held_bytes_q;
	logic [1:0]  held_count_q;
	enc_t        enc;
	logic        adv1;

	umep_encode u_encode (
		.item         (item_s1),
		.cable_number (cable_q),
		.held_bytes   (held_bytes_q),
		.held_count   (held_count_q),
		.enc          (enc)
	);

	assign adv1        = valid_s1 && (!valid_s2 || packets.ready);
	assign items.ready = !valid_s1 || adv1;
	assign cfg.ready   = 1'b1;

	assign packets.valid    = valid_s2;
	assign packets.packet   = res_s2.packet;
	assign packets.rejected = res_s2.rejected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			cable_q      <= '0;
			held_bytes_q <= '0;
			held_count_q <= HELD_NONE;
		end else begin
			if (cfg.valid) begin
				cable_q <= cfg.cable_number;
			end
			if (items.valid && items.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2     <= enc.has_result;
				held_bytes_q <= enc.held_bytes;
				held_count_q <= enc.held_count;
			end else if (packets.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.operation  <= items.operation;
			item_s1.message    <= items.message;
			item_s1.sysex_byte <= items.sysex_byte;
			item_s1.sysex_last <= items.sysex_last;
		end
		if (adv1) begin
			res_s2 <= enc.result;
		end
	end

endmodule

>>> test/tb_usb_midi_event_packetizer_core.sv
`timescale 1ns / 100ps

module tb_usb_midi_event_packetizer_core;
	import umep_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 136;

	typedef struct packed {
		item_t   beat;
		logic    fixed;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	umep_item_if items_bus();
	umep_pkt_if  pkt_bus();
	umep_cfg_if  cfg_bus();

	usb_midi_event_packetizer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_bus),
		.packets (pkt_bus),
		.cfg     (cfg_bus)
	);

	always #2 clk = ~clk;

	// shadow of the block
	logic [3:0]  cable_nr = '0;
	logic [15:0] sysex_hold = '0;
	logic [1:0]  sysex_count = HELD_NONE;

	result_t   packets_due[$];
	stim_row_t stim_rows[$];
	int        errors = 0;
	int        cycles = 0;
	int        stall_left = 0;
	bit        no_idle = 1'b0;

	function automatic stim_row_t row(input logic op, input logic [23:0] msg,
			input logic [7:0] sb, input logic sl, input logic fixed,
			input logic [31:0] pkt, input logic rej);
		stim_row_t r;
		r.beat.operation  = op;
		r.beat.message    = msg;
		r.beat.sysex_byte = sb;
		r.beat.sysex_last = sl;
		r.fixed           = fixed;
		r.want.packet     = pkt;
		r.want.rejected   = rej;
		return r;
	endfunction

	function automatic logic encode_event(input item_t it, output result_t res);
		logic [3:0]  code;
		logic [1:0]  n;
		logic [23:0] payload;
		res = '0;
		if (it.operation == 1'b0) begin
			code = it.message[7:4];
			if (code == STATUS_SYSTEM) begin
				case (it.message[3:0])
					4'h7: code = CIN_SYSEX_END1;
					4'h1, 4'h3: code = CIN_SYS_COMMON2;
					4'h2: code = CIN_SYS_COMMON3;
					4'h4, 4'h5, 4'h9, 4'hD: begin
						res.rejected = 1'b1;
						return 1'b1;
					end
					default: code = CIN_SYSEX_START;
				endcase
			end
			res.packet = {it.message, cable_nr, code};
			return 1'b1;
		end
		n = (sysex_count > HELD_TWO) ? HELD_TWO : sysex_count;
		if (!it.sysex_last && n != HELD_TWO) begin
			if (n == HELD_NONE)
				sysex_hold[7:0] = it.sysex_byte;
			else
				sysex_hold[15:8] = it.sysex_byte;
			sysex_count = n + 2'd1;
			return 1'b0;
		end
		case (n)
			HELD_NONE: payload = {16'h0000, it.sysex_byte};
			HELD_ONE:  payload = {8'h00, it.sysex_byte, sysex_hold[7:0]};
			default:   payload = {it.sysex_byte, sysex_hold};
		endcase
		if (it.sysex_last)
			code = CIN_SYSEX_START + {2'b00, n} + 4'd1;
		else
			code = CIN_SYSEX_START;
		sysex_hold  = '0;
		sysex_count = HELD_NONE;
		res.packet  = {payload, cable_nr, code};
		return 1'b1;
	endfunction

	task automatic send_item(input item_t it, input logic fixed, input result_t want);
		int      gap;
		result_t res;
		logic    has;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			items_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_bus.valid      <= 1'b1;
		items_bus.operation  <= it.operation;
		items_bus.message    <= it.message;
		items_bus.sysex_byte <= it.sysex_byte;
		items_bus.sysex_last <= it.sysex_last;
		do @(posedge clk); while (!items_bus.ready);
		has = encode_event(it, res);
		if (fixed)
			packets_due = {packets_due, want};
		else if (has)
			packets_due = {packets_due, res};
	endtask

	task automatic drain();
		items_bus.valid <= 1'b0;
		while (packets_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cable(input logic [3:0] val);
		drain();
		cfg_bus.valid        <= 1'b1;
		cfg_bus.cable_number <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cable_nr = val;
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic item_t rand_short();
		item_t it;
		it.operation  = 1'b0;
		it.message    = 24'($urandom);
		it.sysex_byte = 8'($urandom);
		it.sysex_last = 1'($urandom);
		if ($urandom_range(0, 2) == 0)
			it.message[7:4] = STATUS_SYSTEM;
		return it;
	endfunction

	function automatic item_t rand_sysex(input logic last);
		item_t it;
		it.operation  = 1'b1;
		it.message    = 24'($urandom);
		it.sysex_byte = 8'($urandom);
		it.sysex_last = last;
		return it;
	endfunction

	// packet side: random stall after each beat
	always @(posedge clk) begin
		int n;
		if (!pkt_bus.ready) begin
			if (stall_left <= 1)
				pkt_bus.ready <= 1'b1;
			else
				stall_left--;
		end else if (pkt_bus.valid) begin
			n = no_idle ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				pkt_bus.ready <= 1'b0;
				stall_left = n;
			end
		end
	end

	always @(posedge clk) begin : packet_check
		result_t want;
		if (arst_n && pkt_bus.valid && pkt_bus.ready) begin
			if (packets_due.size() == 0) begin
				$error("unexpected packet beat: packet %h rejected %b",
					pkt_bus.packet, pkt_bus.rejected);
				errors++;
			end else begin
				want = packets_due.pop_front();
				if (pkt_bus.packet !== want.packet) begin
					$error("packet: expected %h, got %h", want.packet, pkt_bus.packet);
					errors++;
				end
				if (pkt_bus.rejected !== want.rejected) begin
					$error("rejected: expected %b, got %b", want.rejected,
						pkt_bus.rejected);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		item_t   it;
		result_t none;
		int      sent;
		int      len;
		int      kind;
		none = '0;
		items_bus.valid      = 1'b0;
		items_bus.operation  = 1'b0;
		items_bus.message    = '0;
		items_bus.sysex_byte = '0;
		items_bus.sysex_last = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.cable_number = '0;
		pkt_bus.ready        = 1'b1;

		stim_rows = {stim_rows, row(1'b0, 24'h000000, 8'hFF, 1'b1, 1'b1, 32'h00000000, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'hFFFFFF, 8'h00, 1'b0, 1'b1, 32'hFFFFFF04, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h1234F0, 8'hA5, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h007FF1, 8'h5A, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h55AAF2, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h0102F3, 8'hFF, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'hFFFFF4, 8'h11, 1'b0, 1'b1, 32'h00000000, 1'b1)};
		stim_rows = {stim_rows, row(1'b0, 24'h8080F5, 8'h22, 1'b1, 1'b1, 32'h00000000, 1'b1)};
		stim_rows = {stim_rows, row(1'b0, 24'h0000F6, 8'h33, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'hC33CF7, 8'h44, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h7F00F8, 8'h55, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h0F0FF9, 8'h66, 1'b1, 1'b1, 32'h00000000, 1'b1)};
		stim_rows = {stim_rows, row(1'b0, 24'hA5A5FA, 8'h77, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h5A5AFB, 8'h88, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'hFF00FC, 8'h99, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b0, 24'h00FFFD, 8'hAA, 1'b1, 1'b1, 32'h00000000, 1'b1)};
		stim_rows = {stim_rows, row(1'b0, 24'h3C3CFE, 8'hBB, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1, 32'h0000FF05, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'h000000, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'hABCDEF, 8'h80, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'h123456, 8'h12, 1'b0, 1'b0, 32'h0, 1'b0)};
		// short message in the middle of a sysex run
		stim_rows = {stim_rows, row(1'b0, 24'h4007B3, 8'hCC, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'h654321, 8'h34, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'hFEDCBA, 8'h56, 1'b1, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'h0F0F0F, 8'hAA, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'hF0F0F0, 8'h55, 1'b0, 1'b0, 32'h0, 1'b0)};
		stim_rows = {stim_rows, row(1'b1, 24'h800001, 8'h01, 1'b0, 1'b0, 32'h0, 1'b0)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_item(stim_rows[i].beat, stim_rows[i].fixed, stim_rows[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0, 4:    write_cable(4'hF);
				2:       write_cable(4'h0);
				default: write_cable(4'($urandom));
			endcase
			no_idle = (ph % 3 == 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 2 && sent == PHASE_ITEMS / 2)
					drain();
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					send_item(rand_short(), 1'b0, none);
					sent++;
				end else if (kind < 9) begin
					len = $urandom_range(1, 9);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 6) == 0) begin
							send_item(rand_short(), 1'b0, none);
							sent++;
						end
						send_item(rand_sysex(k == len - 1), 1'b0, none);
						sent++;
					end
				end else begin
					// broken run: random ends
					len = $urandom_range(1, 3);
					for (int k = 0; k < len; k++) begin
						it = rand_sysex(1'($urandom));
						it.operation = 1'($urandom);
						send_item(it, 1'b0, none);
						sent++;
					end
				end
			end
		end

		items_bus.valid <= 1'b0;
		while (packets_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
